// ===== sv/chain_bond_wall_energy_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chain bond and wall energy block
// Checks run at the rising edge of i_clk and are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHAIN_BOND_WALL_ENERGY_ASSERT_SVH
`define CHAIN_BOND_WALL_ENERGY_ASSERT_SVH

`ifndef SYNTHESIS

`define CBW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbw check failed");

`define CBW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbw check failed");

`else

`define CBW_ASSERT_IMP(label, ante, cons)

`define CBW_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== sv/cbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_pkg
// Shared types, register map and constants of the chain energy block.
// ----------------------------------------------------------------------------
package cbw_pkg;

    localparam int APB_AW = 4;

    localparam logic [1:0] REG_WALL_LENGTH = 2'd0;
    localparam logic [1:0] REG_PREFACTOR   = 2'd1;
    localparam logic [1:0] REG_CUBE_COEFF  = 2'd2;
    localparam logic [1:0] REG_CUBE_OFFSET = 2'd3;

    localparam logic [30:0]        WALL_LENGTH_RST = 31'd65536;
    localparam logic signed [31:0] PREFACTOR_RST   = 32'sd41177;
    localparam logic [30:0]        CUBE_COEFF_RST  = 31'd30894;
    localparam logic [30:0]        CUBE_OFFSET_RST = 31'd28268;

    localparam logic [63:0] SMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN      = 64'h8000_0000_0000_0000;
    localparam logic [63:0] BOND_K    = 64'd100;
    localparam logic [63:0] BOND_LIM  = 64'd92233720368547758;  // SMAX / 100
    localparam logic [63:0] A10_RECIP = 64'hCCCC_CCCC_CCCC_CCCD;  // ceil(2^66 / 5)
    localparam logic [32:0] ONE_Q16   = 33'd65536;
    localparam logic [63:0] SQRT_TOP  = 64'h4000_0000_0000_0000;

    localparam int DIV_N = 96;

    typedef enum logic [4:0] {
        OP_LOAD, OP_SQX, OP_SQY, OP_SQZ, OP_SQRT, OP_ESQ, OP_BOND, OP_ADDB,
        OP_RDIV, OP_P2, OP_P4, OP_P8, OP_P10, OP_A10, OP_INV1, OP_INV2, OP_INV3,
        OP_BRK, OP_WMUL, OP_ADDW, OP_FIN
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic seen;
        logic z_pos;
        logic long_bond;
        logic last;
        logic out_hold;
    } t_stat;

    // signed add clamped to the 64-bit range; msb of the result flags a clamp
    function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] w;
        w = {a[63], a} + {b[63], b};
        if (w[64] != w[63]) begin
            return {1'b1, (w[64] ? SMIN : SMAX)};
        end
        return {1'b0, w[63:0]};
    endfunction

endpackage

// ===== sv/cbw_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_mul
// 64x64 unsigned multiply from four 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module cbw_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [63:0]  r_a, r_b, r_pp;
    logic [127:0] r_acc;
    logic [1:0]   r_psh;
    logic [2:0]   r_cnt;
    logic         r_run, r_done;

    logic [31:0]  w_ma, w_mb;
    logic [1:0]   w_sh;
    logic [63:0]  w_pp;
    logic [127:0] w_ppx;

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                w_ma = r_a[31:0];  w_mb = r_b[31:0];  w_sh = 2'd0;
            end
            2'd1: begin
                w_ma = r_a[31:0];  w_mb = r_b[63:32]; w_sh = 2'd1;
            end
            2'd2: begin
                w_ma = r_a[63:32]; w_mb = r_b[31:0];  w_sh = 2'd1;
            end
            default: begin
                w_ma = r_a[63:32]; w_mb = r_b[63:32]; w_sh = 2'd2;
            end
        endcase
        w_pp = 64'(w_ma) * 64'(w_mb);
        case (r_psh)
            2'd0:    w_ppx = {64'd0, r_pp};
            2'd1:    w_ppx = {32'd0, r_pp, 32'd0};
            default: w_ppx = {r_pp, 64'd0};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a   <= i_a;
                r_b   <= i_b;
                r_acc <= '0;
                r_cnt <= 3'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_cnt != 3'd4) begin
                    r_pp  <= w_pp;
                    r_psh <= w_sh;
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + w_ppx;
                end
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== sv/cbw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_div
// Restoring divider, 96-bit dividend by 64-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cbw_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [95:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [95:0] o_quo
);

    logic [95:0] r_nq;     // dividend bits shift out the top, quotient bits in
    logic [64:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_run, r_done;

    logic [64:0] w_trial, w_diff;
    logic        w_ge;

    always_comb begin
        w_trial = {r_rem[63:0], r_nq[95]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_nq  <= i_num;
                r_rem <= '0;
                r_den <= i_den;
                r_cnt <= 7'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= w_ge ? w_diff : w_trial;
                r_nq  <= {r_nq[94:0], w_ge};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(cbw_pkg::DIV_N - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_nq;

endmodule

// ===== sv/cbw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_dp
// Datapath: bead registers, chain sums, working values and the shared units.
// ----------------------------------------------------------------------------
module cbw_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbw_pkg::t_cmd      i_cmd,
    output cbw_pkg::t_stat     o_stat,
    input  logic signed [31:0] i_bead_x,
    input  logic signed [31:0] i_bead_y,
    input  logic signed [31:0] i_bead_z,
    input  logic               i_last_bead,
    input  logic [30:0]        i_wall_length,
    input  logic signed [31:0] i_energy_prefactor,
    input  logic [30:0]        i_cube_coeff,
    input  logic [30:0]        i_cube_offset,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [63:0] o_total_energy,
    output logic               o_wall_blocked,
    output logic               o_saturated
);

    logic signed [31:0] r_cur_x, r_cur_y, r_cur_z, r_prev_x, r_prev_y, r_prev_z;
    logic               r_last, r_seen, r_blk, r_ovf, r_done;
    logic [63:0]        r_sum;
    logic [63:0]        r_ssum, r_emag, r_term, r_rr, r_p2, r_p4, r_p8, r_p10;
    logic [63:0]        r_a10, r_inv, r_bmag, r_wmag;
    logic               r_bneg;
    logic [31:0]        r_len;
    cbw_pkg::t_op       r_op;
    logic [63:0]        r_sq_v, r_sq_res, r_sq_bit;
    logic               r_sq_run;
    logic               r_out_valid, r_out_blk, r_out_sat;
    logic [63:0]        r_out_sum;

    logic signed [32:0] w_dx, w_dy, w_dz, w_e;
    logic [32:0]        w_mx, w_my, w_mz, w_emag;
    logic               w_long, w_zpos, w_pneg, w_blk_now;
    logic [31:0]        w_pmag, w_zc;
    logic [63:0]        w_dq, w_c1s;

    logic         w_mul_start, w_mul_done, w_div_start, w_div_done;
    logic [63:0]  w_ma, w_mb, w_den;
    logic [95:0]  w_num, w_quo;
    logic [127:0] w_prod;

    logic [63:0] w_q32, w_q16, w_dval;
    logic        w_s32, w_s16, w_dsat;

    logic [61:0] w_q5;
    logic [63:0] w_q5x, w_r5, w_a10;

    logic [63:0] w_rb, w_res_n, w_v_n;
    logic        w_sq_ge;

    logic [64:0] w_neg65;
    logic [63:0] w_negp;

    logic [63:0] w_tb, w_tw;
    logic        w_sb, w_sw;
    logic [64:0] w_addb, w_addw;

    always_comb begin
        w_dx = {r_cur_x[31], r_cur_x} - {r_prev_x[31], r_prev_x};
        w_dy = {r_cur_y[31], r_cur_y} - {r_prev_y[31], r_prev_y};
        w_dz = {r_cur_z[31], r_cur_z} - {r_prev_z[31], r_prev_z};
        w_mx = w_dx[32] ? 33'(-w_dx) : 33'(w_dx);
        w_my = w_dy[32] ? 33'(-w_dy) : 33'(w_dy);
        w_mz = w_dz[32] ? 33'(-w_dz) : 33'(w_dz);
        w_long = (|w_mx[32:29]) | (|w_my[32:29]) | (|w_mz[32:29]);
        w_e    = $signed({1'b0, r_len}) - $signed(cbw_pkg::ONE_Q16);
        w_emag = w_e[32] ? 33'(-w_e) : 33'(w_e);
        w_zpos = !r_cur_z[31] && (r_cur_z != 32'sd0);
        w_pneg = i_energy_prefactor[31];
        w_pmag = w_pneg ? 32'(-i_energy_prefactor) : 32'(i_energy_prefactor);
        w_zc   = 32'(r_cur_z) + {1'b0, i_cube_offset};
        w_dq   = {16'd0, w_zc, 16'd0};
        w_c1s  = {17'd0, i_cube_coeff, 16'd0};
        w_blk_now = r_blk | !w_zpos;
    end

    // operand selection for the shared multiplier and divider
    always_comb begin
        w_mul_start = i_cmd.start && (i_cmd.op inside {cbw_pkg::OP_SQX, cbw_pkg::OP_SQY,
            cbw_pkg::OP_SQZ, cbw_pkg::OP_ESQ, cbw_pkg::OP_BOND, cbw_pkg::OP_P2,
            cbw_pkg::OP_P4, cbw_pkg::OP_P8, cbw_pkg::OP_P10, cbw_pkg::OP_A10,
            cbw_pkg::OP_WMUL});
        w_div_start = i_cmd.start && (i_cmd.op inside {cbw_pkg::OP_RDIV,
            cbw_pkg::OP_INV1, cbw_pkg::OP_INV2, cbw_pkg::OP_INV3});
        case (i_cmd.op)
            cbw_pkg::OP_SQX: begin w_ma = 64'(w_mx);   w_mb = 64'(w_mx); end
            cbw_pkg::OP_SQY: begin w_ma = 64'(w_my);   w_mb = 64'(w_my); end
            cbw_pkg::OP_SQZ: begin w_ma = 64'(w_mz);   w_mb = 64'(w_mz); end
            cbw_pkg::OP_ESQ: begin w_ma = 64'(w_emag); w_mb = 64'(w_emag); end
            cbw_pkg::OP_BOND: begin w_ma = r_emag;     w_mb = cbw_pkg::BOND_K; end
            cbw_pkg::OP_P2:  begin w_ma = r_rr;        w_mb = r_rr; end
            cbw_pkg::OP_P4:  begin w_ma = r_p2;        w_mb = r_p2; end
            cbw_pkg::OP_P8:  begin w_ma = r_p4;        w_mb = r_p4; end
            cbw_pkg::OP_P10: begin w_ma = r_p8;        w_mb = r_p2; end
            cbw_pkg::OP_A10: begin w_ma = r_p10;       w_mb = cbw_pkg::A10_RECIP; end
            cbw_pkg::OP_WMUL: begin w_ma = r_bmag;     w_mb = 64'(w_pmag); end
            default:         begin w_ma = '0;          w_mb = '0; end
        endcase
        case (i_cmd.op)
            cbw_pkg::OP_RDIV: begin
                w_num = {33'd0, i_wall_length, 32'd0};
                w_den = {32'd0, r_cur_z};
            end
            cbw_pkg::OP_INV1: begin
                w_num = {w_c1s, 32'd0};
                w_den = w_dq;
            end
            default: begin
                w_num = {r_inv, 32'd0};
                w_den = w_dq;
            end
        endcase
    end

    cbw_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    cbw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_comb begin
        w_s32  = |w_prod[127:96];
        w_q32  = w_s32 ? '1 : w_prod[95:32];
        w_s16  = |w_prod[127:80];
        w_q16  = w_s16 ? '1 : w_prod[79:16];
        w_dsat = |w_quo[95:64];
        w_dval = w_dsat ? '1 : w_quo[63:0];

        // 0.4*p10 = 2*(p10/5) + (1 if the remainder is 3 or 4)
        w_q5  = w_prod[127:66];
        w_q5x = {w_q5, 2'b00} + {2'b00, w_q5};
        w_r5  = r_p10 - w_q5x;
        w_a10 = {1'b0, w_q5, 1'b0} + 64'(w_r5 > 64'd2);

        // one step of the bitwise integer square root
        w_rb    = r_sq_res + r_sq_bit;
        w_sq_ge = r_sq_v >= w_rb;
        w_res_n = w_sq_ge ? (r_sq_res >> 1) + r_sq_bit : r_sq_res >> 1;
        w_v_n   = w_sq_ge ? r_sq_v - w_rb : r_sq_v;

        // bracket: 0.4*(s/z)^10 - ((s/z)^4 + c1/(z+c2)^3) as sign and magnitude
        w_neg65 = {1'b0, r_p4} + {1'b0, r_inv};
        w_negp  = w_neg65[64] ? '1 : w_neg65[63:0];

        w_sb   = w_long || (r_emag > cbw_pkg::BOND_LIM);
        w_tb   = w_sb ? cbw_pkg::SMAX : r_term;
        w_addb = cbw_pkg::sat_add(r_sum, w_tb);

        if (r_bneg != w_pneg) begin
            w_sw = r_wmag[63] && (|r_wmag[62:0]);
            w_tw = r_wmag[63] ? cbw_pkg::SMIN : 64'(-r_wmag);
        end else begin
            w_sw = r_wmag[63];
            w_tw = r_wmag[63] ? cbw_pkg::SMAX : r_wmag;
        end
        w_addw = cbw_pkg::sat_add(r_sum, w_tw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_seen      <= 1'b0;
            r_sum       <= '0;
            r_blk       <= 1'b0;
            r_ovf       <= 1'b0;
            r_done      <= 1'b0;
            r_sq_run    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load) begin
                r_cur_x <= i_bead_x;
                r_cur_y <= i_bead_y;
                r_cur_z <= i_bead_z;
                r_last  <= i_last_bead;
            end
            if (i_cmd.start) begin
                r_op <= i_cmd.op;
                case (i_cmd.op)
                    cbw_pkg::OP_SQRT: begin
                        r_sq_v   <= r_ssum;
                        r_sq_res <= '0;
                        r_sq_bit <= cbw_pkg::SQRT_TOP;
                        r_sq_run <= 1'b1;
                    end
                    cbw_pkg::OP_ADDB: begin
                        r_sum  <= w_addb[63:0];
                        r_ovf  <= r_ovf | w_sb | w_addb[64];
                        r_done <= 1'b1;
                    end
                    cbw_pkg::OP_BRK: begin
                        r_bneg <= r_a10 < w_negp;
                        r_bmag <= (r_a10 < w_negp) ? w_negp - r_a10 : r_a10 - w_negp;
                        r_ovf  <= r_ovf | w_neg65[64];
                        r_done <= 1'b1;
                    end
                    cbw_pkg::OP_ADDW: begin
                        r_sum  <= w_addw[63:0];
                        r_ovf  <= r_ovf | w_sw | w_addw[64];
                        r_done <= 1'b1;
                    end
                    cbw_pkg::OP_FIN: begin
                        r_done <= 1'b1;
                        if (r_last) begin
                            r_out_valid <= 1'b1;
                            r_out_sum   <= r_sum;
                            r_out_blk   <= w_blk_now;
                            r_out_sat   <= r_ovf;
                            r_prev_x    <= '0;
                            r_prev_y    <= '0;
                            r_prev_z    <= '0;
                            r_seen      <= 1'b0;
                            r_sum       <= '0;
                            r_blk       <= 1'b0;
                            r_ovf       <= 1'b0;
                        end else begin
                            r_prev_x <= r_cur_x;
                            r_prev_y <= r_cur_y;
                            r_prev_z <= r_cur_z;
                            r_seen   <= 1'b1;
                            r_blk    <= w_blk_now;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_sq_run) begin
                r_sq_v   <= w_v_n;
                r_sq_res <= w_res_n;
                r_sq_bit <= r_sq_bit >> 2;
                if (r_sq_bit[0]) begin
                    r_sq_run <= 1'b0;
                    r_len    <= w_res_n[31:0];
                    r_done   <= 1'b1;
                end
            end
            if (w_mul_done) begin
                r_done <= 1'b1;
                case (r_op)
                    cbw_pkg::OP_SQX:  r_ssum <= w_prod[63:0];
                    cbw_pkg::OP_SQY,
                    cbw_pkg::OP_SQZ:  r_ssum <= r_ssum + w_prod[63:0];
                    cbw_pkg::OP_ESQ:  r_emag <= w_prod[63:0];
                    cbw_pkg::OP_BOND: r_term <= w_prod[63:0];
                    cbw_pkg::OP_P2: begin
                        r_p2  <= w_q32;
                        r_ovf <= r_ovf | w_s32;
                    end
                    cbw_pkg::OP_P4: begin
                        r_p4  <= w_q32;
                        r_ovf <= r_ovf | w_s32;
                    end
                    cbw_pkg::OP_P8: begin
                        r_p8  <= w_q32;
                        r_ovf <= r_ovf | w_s32;
                    end
                    cbw_pkg::OP_P10: begin
                        r_p10 <= w_q32;
                        r_ovf <= r_ovf | w_s32;
                    end
                    cbw_pkg::OP_A10:  r_a10 <= w_a10;
                    default: begin
                        r_wmag <= w_q16;
                        r_ovf  <= r_ovf | w_s16;
                    end
                endcase
            end
            if (w_div_done) begin
                r_done <= 1'b1;
                case (r_op)
                    cbw_pkg::OP_RDIV: begin
                        r_rr  <= w_dval;
                        r_ovf <= r_ovf | w_dsat;
                    end
                    default: begin
                        r_inv <= w_dval;
                        r_ovf <= r_ovf | w_dsat;
                    end
                endcase
            end
        end
    end

    assign o_stat = '{done:      r_done,
                      seen:      r_seen,
                      z_pos:     w_zpos,
                      long_bond: w_long,
                      last:      r_last,
                      out_hold:  r_out_valid & ~i_out_ready};

    assign o_out_valid    = r_out_valid;
    assign o_total_energy = $signed(r_out_sum);
    assign o_wall_blocked = r_out_blk;
    assign o_saturated    = r_out_sat;

endmodule

// ===== sv/cbw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbw_ctrl
// Sequencer: walks one bead through the bond and wall steps of the datapath.
// ----------------------------------------------------------------------------
module cbw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output cbw_pkg::t_cmd  o_cmd,
    input  cbw_pkg::t_stat i_stat
);

    typedef enum logic [1:0] {S_IDLE, S_PICK, S_ISSUE, S_WAIT} t_state;

    t_state       r_state;
    cbw_pkg::t_op r_op, n_op, w_wall_op;
    logic         r_ready, r_start;

    always_comb begin
        w_wall_op = i_stat.z_pos ? cbw_pkg::OP_RDIV : cbw_pkg::OP_FIN;
        case (r_op)
            cbw_pkg::OP_LOAD: begin
                if (!i_stat.seen) begin
                    n_op = w_wall_op;
                end else begin
                    n_op = i_stat.long_bond ? cbw_pkg::OP_ADDB : cbw_pkg::OP_SQX;
                end
            end
            cbw_pkg::OP_SQX:  n_op = cbw_pkg::OP_SQY;
            cbw_pkg::OP_SQY:  n_op = cbw_pkg::OP_SQZ;
            cbw_pkg::OP_SQZ:  n_op = cbw_pkg::OP_SQRT;
            cbw_pkg::OP_SQRT: n_op = cbw_pkg::OP_ESQ;
            cbw_pkg::OP_ESQ:  n_op = cbw_pkg::OP_BOND;
            cbw_pkg::OP_BOND: n_op = cbw_pkg::OP_ADDB;
            cbw_pkg::OP_ADDB: n_op = w_wall_op;
            cbw_pkg::OP_RDIV: n_op = cbw_pkg::OP_P2;
            cbw_pkg::OP_P2:   n_op = cbw_pkg::OP_P4;
            cbw_pkg::OP_P4:   n_op = cbw_pkg::OP_P8;
            cbw_pkg::OP_P8:   n_op = cbw_pkg::OP_P10;
            cbw_pkg::OP_P10:  n_op = cbw_pkg::OP_A10;
            cbw_pkg::OP_A10:  n_op = cbw_pkg::OP_INV1;
            cbw_pkg::OP_INV1: n_op = cbw_pkg::OP_INV2;
            cbw_pkg::OP_INV2: n_op = cbw_pkg::OP_INV3;
            cbw_pkg::OP_INV3: n_op = cbw_pkg::OP_BRK;
            cbw_pkg::OP_BRK:  n_op = cbw_pkg::OP_WMUL;
            cbw_pkg::OP_WMUL: n_op = cbw_pkg::OP_ADDW;
            default:          n_op = cbw_pkg::OP_FIN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b1;
            r_start <= 1'b0;
            r_op    <= cbw_pkg::OP_LOAD;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_ready <= 1'b0;
                        r_op    <= cbw_pkg::OP_LOAD;
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_op    <= n_op;
                    r_state <= S_ISSUE;
                end
                S_ISSUE: begin
                    // the closing step of a chain waits for a free result slot
                    if (!(r_op == cbw_pkg::OP_FIN && i_stat.last && i_stat.out_hold)) begin
                        r_start <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (i_stat.done) begin
                        if (r_op == cbw_pkg::OP_FIN) begin
                            r_ready <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PICK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = r_ready;
    assign o_cmd.load  = i_valid & r_ready;
    assign o_cmd.start = r_start;
    assign o_cmd.op    = r_op;

endmodule

// ===== sv/chain_bond_wall_energy.sv =====
`timescale 1ns / 1ps
// Each bead after the first runs the bond steps; a bead with z > 0 also runs the wall steps,
// which a bead on or below the wall skips; the result word follows the last bead.
// Beads are taken one at a time; the four 96-step divisions on the single shared divider
// take most of the work, the 4-product multiplier and 32-step root add the rest.
// Reset (synchronous, active low) clears the chain state and loads register defaults.
// ----------------------------------------------------------------------------
// chain_bond_wall_energy
// Bond and wall energy of a bead chain, Q16.16 in, saturated Q32.32 out.
// ----------------------------------------------------------------------------
`include "chain_bond_wall_energy_assert.svh"

module chain_bond_wall_energy (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_bead_x,
    input  logic signed [31:0]          i_bead_y,
    input  logic signed [31:0]          i_bead_z,
    input  logic                        i_last_bead,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [63:0]          o_total_energy,
    output logic                        o_wall_blocked,
    output logic                        o_saturated,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cbw_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [30:0]        r_wall_length, r_cube_coeff, r_cube_offset;
    logic signed [31:0] r_energy_prefactor;

    cbw_pkg::t_cmd  w_cmd;
    cbw_pkg::t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_length      <= cbw_pkg::WALL_LENGTH_RST;
            r_energy_prefactor <= cbw_pkg::PREFACTOR_RST;
            r_cube_coeff       <= cbw_pkg::CUBE_COEFF_RST;
            r_cube_offset      <= cbw_pkg::CUBE_OFFSET_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                cbw_pkg::REG_WALL_LENGTH: r_wall_length      <= pwdata[30:0];
                cbw_pkg::REG_PREFACTOR:   r_energy_prefactor <= $signed(pwdata);
                cbw_pkg::REG_CUBE_COEFF:  r_cube_coeff       <= pwdata[30:0];
                cbw_pkg::REG_CUBE_OFFSET: r_cube_offset      <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            cbw_pkg::REG_WALL_LENGTH: prdata = {1'b0, r_wall_length};
            cbw_pkg::REG_PREFACTOR:   prdata = r_energy_prefactor;
            cbw_pkg::REG_CUBE_COEFF:  prdata = {1'b0, r_cube_coeff};
            cbw_pkg::REG_CUBE_OFFSET: prdata = {1'b0, r_cube_offset};
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    cbw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    cbw_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_bead_x           (i_bead_x),
        .i_bead_y           (i_bead_y),
        .i_bead_z           (i_bead_z),
        .i_last_bead        (i_last_bead),
        .i_wall_length      (r_wall_length),
        .i_energy_prefactor (r_energy_prefactor),
        .i_cube_coeff       (r_cube_coeff),
        .i_cube_offset      (r_cube_offset),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_total_energy     (o_total_energy),
        .o_wall_blocked     (o_wall_blocked),
        .o_saturated        (o_saturated)
    );

    // no step is launched while the block takes beads
    `CBW_ASSERT_IMP(a_no_start_idle, o_ready, !w_cmd.start)
    // an accepted bead makes the block busy at once
    `CBW_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // a datapath step completes only while the sequencer is busy
    `CBW_ASSERT_IMP(a_done_busy, w_stat.done, !o_ready)

endmodule
